/* hw/rtl/assert_macros.svh */
// assertion macros shared by the checker files
// no dependencies; every macro samples on the rising clock edge and is off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hw/rtl/mmgc_pkg.sv */
// shared constants, types and helper functions of the gradient contrast block
// no dependencies
package mmgc_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);

    localparam int SIZE_W     = 13;
    localparam int PIX_W      = 8;
    localparam int LUMA_W     = 24;
    localparam int TERM_W     = LUMA_W + 1;
    localparam int SUM_W      = 50;
    localparam int CNT_W      = 24;
    localparam int MEAN_W     = 17;
    localparam int SCALE_W    = 9;
    localparam int DEN_W      = CNT_W + SCALE_W;
    localparam int REM_W      = SUM_W + 1;
    localparam int STEP_W     = $clog2(MEAN_W);

    localparam int S_TDATA_W  = 6 * PIX_W;
    localparam int M_TDATA_W  = ((MEAN_W + CNT_W + 7) / 8) * 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = SIZE_W;

    // rec.709 weights in q0.16
    localparam logic [15:0] W_RED   = 16'd13933;
    localparam logic [15:0] W_GREEN = 16'd46871;
    localparam logic [15:0] W_BLUE  = 16'd4732;

    // 2 * 255: one diff pair at full scale
    localparam logic [SCALE_W-1:0] DEN_SCALE = 9'd510;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_GRAY_MODE    = 2'd2,
        REG_MASK_ENABLE  = 2'd3
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_LUMA,
        ST_DIFF,
        ST_ACC,
        ST_DEN,
        ST_NUM,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load_in;
        logic mul;
        logic luma;
        logic diff;
        logic acc;
        logic den;
        logic num;
        logic div_step;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic frame_end;
        logic div_last;
        logic out_free;
    } dp_stat_t;

    function automatic logic [LUMA_W-1:0] abs_diff(input logic [LUMA_W-1:0] a,
                                                   input logic [LUMA_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

/* hw/rtl/mmgc_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
module mmgc_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* hw/rtl/mmgc_ctrl.sv */
// per-pixel and end-of-frame sequencer of the gradient contrast block
// depends on mmgc_pkg
module mmgc_ctrl import mmgc_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:  state_next = ST_LUMA;
            ST_LUMA: state_next = ST_DIFF;
            ST_DIFF: state_next = ST_ACC;
            ST_ACC:  state_next = stat.frame_end ? ST_DEN : ST_IDLE;
            ST_DEN:  state_next = ST_NUM;
            ST_NUM:  state_next = ST_DIV;
            ST_DIV: begin
                if (stat.div_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            ST_MUL:  cmd.mul      = 1'b1;
            ST_LUMA: cmd.luma     = 1'b1;
            ST_DIFF: cmd.diff     = 1'b1;
            ST_ACC:  cmd.acc      = 1'b1;
            ST_DEN:  cmd.den      = 1'b1;
            ST_NUM:  cmd.num      = 1'b1;
            ST_DIV:  cmd.div_step = 1'b1;
            ST_DONE: cmd.out_load = stat.out_free;
            default: cmd = '0;
        endcase
    end

endmodule

/* hw/rtl/mmgc_dp.sv */
// datapath: config registers, luma, line store, accumulators, divider, output register
// depends on mmgc_pkg and mmgc_ram
module mmgc_dp import mmgc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic [PIX_W-1:0]      red,
    input  logic [PIX_W-1:0]      green,
    input  logic [PIX_W-1:0]      blue,
    input  logic [PIX_W-1:0]      mask_red,
    input  logic [PIX_W-1:0]      mask_green,
    input  logic [PIX_W-1:0]      mask_blue,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata
);

    // config
    logic [SIZE_W-1:0] frame_width_reg, frame_height_reg;
    logic              gray_mode_reg, mask_enable_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= '0;
            frame_height_reg <= '0;
            gray_mode_reg    <= 1'b0;
            mask_enable_reg  <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata[SIZE_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata[SIZE_W-1:0];
                REG_GRAY_MODE:    gray_mode_reg    <= cfg_wdata[0];
                REG_MASK_ENABLE:  mask_enable_reg  <= cfg_wdata[0];
            endcase
        end
    end

    // last column and last row index, zero size as one, oversize saturated
    logic [31:0]      fw32, fh32, wm1_32, hm1_32;
    logic [COL_W-1:0] wm1;
    logic [ROW_W-1:0] hm1;

    always_comb begin
        fw32 = 32'(frame_width_reg);
        fh32 = 32'(frame_height_reg);
        if (fw32 == 32'd0) begin
            wm1_32 = 32'd0;
        end else if (fw32 > 32'(MAX_WIDTH)) begin
            wm1_32 = 32'(MAX_WIDTH - 1);
        end else begin
            wm1_32 = fw32 - 32'd1;
        end
        if (fh32 == 32'd0) begin
            hm1_32 = 32'd0;
        end else if (fh32 > 32'(MAX_HEIGHT)) begin
            hm1_32 = 32'(MAX_HEIGHT - 1);
        end else begin
            hm1_32 = fh32 - 32'd1;
        end
        wm1 = wm1_32[COL_W-1:0];
        hm1 = hm1_32[ROW_W-1:0];
    end

    // input capture
    logic [PIX_W-1:0] r_reg, g_reg, b_reg;
    logic             allow_reg;
    logic             allow_now;

    always_comb begin
        if (!mask_enable_reg) begin
            allow_now = 1'b1;
        end else if (gray_mode_reg) begin
            allow_now = (mask_red != '0);
        end else begin
            allow_now = ((mask_red | mask_green | mask_blue) != '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            r_reg     <= red;
            g_reg     <= green;
            b_reg     <= blue;
            allow_reg <= allow_now;
        end
    end

    // luma: three weighted products, then their sum; in grey mode red alone
    logic [LUMA_W-1:0] prod_r_reg, prod_g_reg, prod_b_reg, luma_reg;

    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            prod_r_reg <= LUMA_W'(r_reg) * LUMA_W'(W_RED);
            prod_g_reg <= LUMA_W'(g_reg) * LUMA_W'(W_GREEN);
            prod_b_reg <= LUMA_W'(b_reg) * LUMA_W'(W_BLUE);
        end
        if (cmd.luma) begin
            luma_reg <= gray_mode_reg ? {r_reg, 16'h0000}
                                      : (prod_r_reg + prod_g_reg + prod_b_reg);
        end
    end

    // position and running sums
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [LUMA_W-1:0] left_luma_reg;
    logic [SUM_W-1:0]  sum_reg, fin_sum_reg, sum_next;
    logic [CNT_W-1:0]  cnt_reg, fin_cnt_reg, cnt_next;
    logic              row_end, frame_end;

    assign row_end   = (col_reg >= wm1);
    assign frame_end = row_end && (row_reg >= hm1);

    // line store: {allowed, luma} per column, and right-hand difference per column
    logic [LUMA_W:0]   lum_rd;
    logic [LUMA_W-1:0] hd_rd;
    logic [LUMA_W-1:0] hd_new_reg;
    logic [TERM_W-1:0] term_reg;
    logic              contrib_reg;

    mmgc_ram #(
        .DATA_W (LUMA_W + 1),
        .DEPTH  (MAX_WIDTH)
    ) u_line_luma (
        .aclk    (aclk),
        .wr_en   (cmd.acc),
        .wr_addr (col_reg),
        .wr_data ({allow_reg, luma_reg}),
        .rd_en   (cmd.load_in),
        .rd_addr (col_reg),
        .rd_data (lum_rd)
    );

    mmgc_ram #(
        .DATA_W (LUMA_W),
        .DEPTH  (MAX_WIDTH)
    ) u_line_hdiff (
        .aclk    (aclk),
        .wr_en   (cmd.acc && (col_reg != '0)),
        .wr_addr (col_reg - COL_W'(1)),
        .wr_data (hd_new_reg),
        .rd_en   (cmd.load_in),
        .rd_addr (col_reg),
        .rd_data (hd_rd)
    );

    always_ff @(posedge aclk) begin
        if (cmd.diff) begin
            term_reg    <= TERM_W'(hd_rd) + TERM_W'(abs_diff(lum_rd[LUMA_W-1:0], luma_reg));
            contrib_reg <= (row_reg != '0) && (col_reg < wm1) && lum_rd[LUMA_W];
            hd_new_reg  <= abs_diff(left_luma_reg, luma_reg);
        end
    end

    assign sum_next = sum_reg + (contrib_reg ? SUM_W'(term_reg) : '0);
    assign cnt_next = cnt_reg + CNT_W'(contrib_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg       <= '0;
            row_reg       <= '0;
            left_luma_reg <= '0;
            sum_reg       <= '0;
            cnt_reg       <= '0;
        end else if (cmd.acc) begin
            left_luma_reg <= luma_reg;
            if (frame_end) begin
                col_reg <= '0;
                row_reg <= '0;
                sum_reg <= '0;
                cnt_reg <= '0;
            end else begin
                sum_reg <= sum_next;
                cnt_reg <= cnt_next;
                if (row_end) begin
                    col_reg <= '0;
                    row_reg <= row_reg + ROW_W'(1);
                end else begin
                    col_reg <= col_reg + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.acc && frame_end) begin
            fin_sum_reg <= sum_next;
            fin_cnt_reg <= cnt_next;
        end
    end

    // rounded mean: restoring division, one quotient bit per step
    logic [DEN_W-1:0]  den_reg;
    logic [REM_W-1:0]  rem_reg, dsh_reg;
    logic [MEAN_W-1:0] quo_reg;
    logic [STEP_W-1:0] step_reg;
    logic              fits;

    assign fits = (rem_reg >= dsh_reg);

    always_ff @(posedge aclk) begin
        if (cmd.den) begin
            den_reg <= DEN_W'(fin_cnt_reg) * DEN_W'(DEN_SCALE);
        end
        if (cmd.num) begin
            rem_reg  <= REM_W'(fin_sum_reg) + REM_W'(den_reg >> 1);
            dsh_reg  <= REM_W'(den_reg) << (MEAN_W - 1);
            quo_reg  <= '0;
            step_reg <= '0;
        end else if (cmd.div_step) begin
            if (fits) begin
                rem_reg <= rem_reg - dsh_reg;
            end
            quo_reg  <= {quo_reg[MEAN_W-2:0], fits};
            dsh_reg  <= dsh_reg >> 1;
            step_reg <= step_reg + STEP_W'(1);
        end
    end

    // output register
    logic              out_valid_reg;
    logic [MEAN_W-1:0] out_mean_reg;
    logic [CNT_W-1:0]  out_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_mean_reg <= (fin_cnt_reg == '0) ? '0 : quo_reg;
            out_cnt_reg  <= fin_cnt_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - MEAN_W - CNT_W){1'b0}}, out_cnt_reg, out_mean_reg};

    assign stat.frame_end = frame_end;
    assign stat.div_last  = (step_reg == STEP_W'(MEAN_W - 1));
    assign stat.out_free  = !out_valid_reg || m_tready;

endmodule

/* hw/rtl/masked_mean_gradient_contrast.sv */
// masked mean gradient contrast: top level, sequencer plus datapath
// the sequencer takes one pixel at a time: it passes each request through the
// line store read, luma products, difference and accumulate before it accepts another
// results: the frame's last pixel gives its result after its accumulate and the
// shift-subtract divider, held while the output stalls; nothing for any other pixel
// reset: aresetn synchronous active low clears position, sums, config and output
// valid; the line store is not cleared and needs no clearing pass
// depends on mmgc_pkg, mmgc_ctrl, mmgc_dp
module masked_mean_gradient_contrast import mmgc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,

    // config write port, index = register number
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    // pixel requests
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // red, green, blue, mask_red, mask_green, mask_blue (8 bits each, lowest first)
    input  logic [S_TDATA_W-1:0]  s_tdata,

    // frame results
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // contrast_mean [16:0], counted_pixels [40:17], zero padding above
    output logic [M_TDATA_W-1:0]  m_tdata
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // unpack pixel fields
    logic [PIX_W-1:0] red, green, blue, mask_red, mask_green, mask_blue;

    assign red        = s_tdata[0*PIX_W +: PIX_W];
    assign green      = s_tdata[1*PIX_W +: PIX_W];
    assign blue       = s_tdata[2*PIX_W +: PIX_W];
    assign mask_red   = s_tdata[3*PIX_W +: PIX_W];
    assign mask_green = s_tdata[4*PIX_W +: PIX_W];
    assign mask_blue  = s_tdata[5*PIX_W +: PIX_W];

    // sequencer: one pixel at a time, divider only at the frame's end
    mmgc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath with line store and result register
    mmgc_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .mask_red   (mask_red),
        .mask_green (mask_green),
        .mask_blue  (mask_blue),
        .cmd        (cmd),
        .stat       (stat),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

/* hw/rtl/mmgc_checker.sv */
// port-level checks of the gradient contrast block, bound to the top level
// depends on mmgc_pkg and assert_macros.svh
`include "assert_macros.svh"

module mmgc_checker import mmgc_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // a stalled result stays put
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // a pixel request keeps the sequencer busy for the next cycle
    `ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    // no counted pixel means zero contrast
    `ASSERT_IMPLY(a_empty_zero, aclk, aresetn, m_tvalid && (m_tdata[MEAN_W +: CNT_W] == '0), m_tdata[MEAN_W-1:0] == '0)

    // mean never exceeds full scale and padding stays clear
    `ASSERT_IMPLY(a_mean_range, aclk, aresetn, m_tvalid, (m_tdata[MEAN_W-1:0] <= 17'd65536) && (m_tdata[M_TDATA_W-1:MEAN_W+CNT_W] == '0))

endmodule

bind masked_mean_gradient_contrast mmgc_checker u_mmgc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* verif/masked_mean_gradient_contrast_tb.sv */
// testbench for masked_mean_gradient_contrast: streams raster pixels, predicts each frame's
// mean gradient contrast and pixel count in step with accepted requests and checks every result
// depends on mmgc_pkg and masked_mean_gradient_contrast
module masked_mean_gradient_contrast_tb;
    import mmgc_pkg::*;

    // line store depth and row limit of the block as built
    localparam int unsigned LINE_MAX = 4096;
    localparam int unsigned ROWS_MAX = 4096;

    // rec.709 luma weights, q0.16
    localparam int unsigned LUMA_WR = 13933;
    localparam int unsigned LUMA_WG = 46871;
    localparam int unsigned LUMA_WB = 4732;

    // quiet time before a register write, covers the frame-end divide
    localparam int DRAIN_CYCLES = 40;
    localparam int unsigned LIMIT_CYCLES = 3000000;

    // red sits in the lowest byte of s_tdata
    typedef struct packed {
        logic [7:0] mask_blue;
        logic [7:0] mask_green;
        logic [7:0] mask_red;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    typedef struct {
        logic [16:0] mean;
        logic [23:0] pixels;
    } frame_result_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    // red, green, blue, mask_red, mask_green, mask_blue (8 bits each, lowest first)
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    // contrast_mean [16:0], counted_pixels [40:17], zero padding above
    logic [M_TDATA_W-1:0]  m_tdata;

    masked_mean_gradient_contrast dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor state: a private copy of the registers and the line store
    // ------------------------------------------------------------------
    logic [12:0] cfg_width  = '0;
    logic [12:0] cfg_height = '0;
    bit          cfg_gray   = 1'b0;
    bit          cfg_mask   = 1'b0;

    logic [31:0] line_luma  [LINE_MAX];
    logic [31:0] line_hdiff [LINE_MAX];
    bit          line_allow [LINE_MAX];
    logic [31:0] left_luma  = '0;
    int unsigned col_pos    = 0;
    int unsigned row_pos    = 0;
    logic [63:0] grad_sum   = '0;
    int unsigned counted    = 0;

    frame_result_t pending_contrast [$];

    int unsigned pixels_sent      = 0;
    int unsigned mismatch_count   = 0;
    int unsigned cycle_count      = 0;
    // percent chance of an idle burst before each request, half that per result cycle; 0 = none
    int unsigned idle_odds        = 0;

    function automatic logic [31:0] luma_gap(input logic [31:0] a, input logic [31:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // zero counts as one, anything past the store saturates
    function automatic int unsigned clip_size(input logic [12:0] v, input int unsigned top);
        if (v == 0) return 1;
        if (v > top) return top;
        return int'(v);
    endfunction

    // advance the frame by one accepted pixel, queue a result at the frame's last pixel
    function automatic void advance_contrast(input pixel_t px);
        int unsigned   w;
        int unsigned   h;
        int unsigned   x;
        logic [31:0]   luma;
        bit            allow;
        logic [63:0]   den;
        frame_result_t res;
        w = clip_size(cfg_width, LINE_MAX);
        h = clip_size(cfg_height, ROWS_MAX);
        x = (col_pos >= LINE_MAX) ? LINE_MAX - 1 : col_pos;
        if (cfg_gray) begin
            luma  = {8'd0, px.red, 16'd0};
            allow = !cfg_mask || (px.mask_red != 0);
        end else begin
            luma  = LUMA_WR * px.red + LUMA_WG * px.green + LUMA_WB * px.blue;
            allow = !cfg_mask || (px.mask_red != 0) || (px.mask_green != 0)
                    || (px.mask_blue != 0);
        end
        // centre is the pixel above: its right diff was stored, the down diff is new
        if (row_pos >= 1 && x + 1 < w && line_allow[x]) begin
            grad_sum += 64'(line_hdiff[x]) + 64'(luma_gap(line_luma[x], luma));
            counted++;
        end
        if (x >= 1)
            line_hdiff[x - 1] = luma_gap(left_luma, luma);
        line_luma[x]  = luma;
        line_allow[x] = allow;
        left_luma     = luma;
        if (x + 1 >= w) begin
            col_pos = 0;
            if (row_pos + 1 >= h) begin
                res.pixels = counted[23:0];
                if (counted == 0) begin
                    res.mean = '0;
                end else begin
                    // round half up
                    den      = 64'd510 * counted;
                    res.mean = 17'((grad_sum + den / 2) / den);
                end
                pending_contrast = {pending_contrast, res};
                row_pos  = 0;
                grad_sum = '0;
                counted  = 0;
            end else begin
                row_pos++;
            end
        end else begin
            col_pos = x + 1;
        end
    endfunction

    function automatic pixel_t pix(input logic [7:0] r, input logic [7:0] g,
                                   input logic [7:0] b, input logic [7:0] mr,
                                   input logic [7:0] mg, input logic [7:0] mb);
        return {mb, mg, mr, b, g, r};
    endfunction

    // style 0: noise, 1: smooth area with small ripples, other: hard black and white
    function automatic pixel_t make_pixel(input int unsigned style);
        pixel_t     px;
        logic [7:0] base;
        int unsigned ch;
        base = 8'($urandom_range(0, 255));
        case (style)
            0: begin
                px.red   = 8'($urandom_range(0, 255));
                px.green = 8'($urandom_range(0, 255));
                px.blue  = 8'($urandom_range(0, 255));
            end
            1: begin
                px.red   = base ^ 8'($urandom_range(0, 3));
                px.green = base ^ 8'($urandom_range(0, 3));
                px.blue  = base ^ 8'($urandom_range(0, 3));
            end
            default: begin
                px.red   = $urandom_range(0, 1) ? 8'hff : 8'h00;
                px.green = $urandom_range(0, 1) ? 8'hff : 8'h00;
                px.blue  = $urandom_range(0, 1) ? 8'hff : 8'h00;
            end
        endcase
        // mask: blocked, a single live channel, or anything
        px.mask_red   = '0;
        px.mask_green = '0;
        px.mask_blue  = '0;
        case ($urandom_range(0, 3))
            0: ;
            1: begin
                ch = $urandom_range(0, 2);
                if (ch == 0) px.mask_red = 8'($urandom_range(1, 255));
                else if (ch == 1) px.mask_green = 8'($urandom_range(1, 255));
                else px.mask_blue = 8'($urandom_range(1, 255));
            end
            default: begin
                px.mask_red   = 8'($urandom_range(0, 255));
                px.mask_green = 8'($urandom_range(0, 255));
                px.mask_blue  = 8'($urandom_range(0, 255));
            end
        endcase
        return px;
    endfunction

    // mostly tiny frames, now and then a wider one
    function automatic logic [12:0] pick_size(input int unsigned top);
        if ($urandom_range(0, 7) == 0) return 13'($urandom_range(9, top));
        return 13'($urandom_range(0, 8));
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    // ------------------------------------------------------------------
    // stimulus side
    // ------------------------------------------------------------------

    // one pixel request, with an optional idle burst in front; predicted once accepted
    task automatic send_pixel(input pixel_t px);
        if (idle_odds != 0 && $urandom_range(0, 99) < idle_odds) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_tdata  <= px;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        pixels_sent++;
        advance_contrast(px);
    endtask

    // keep streaming until the raster position wraps to the frame start
    task automatic finish_frame(input int unsigned style);
        do send_pixel(make_pixel(style)); while (col_pos != 0 || row_pos != 0);
    endtask

    // stop requesting, let every result out and the divider settle
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_contrast.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            REG_FRAME_WIDTH:  cfg_width  = val;
            REG_FRAME_HEIGHT: cfg_height = val;
            REG_GRAY_MODE:    cfg_gray   = val[0];
            REG_MASK_ENABLE:  cfg_mask   = val[0];
            default: ;
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_frame(input logic [12:0] w, input logic [12:0] h,
                             input bit gray, input bit mask_on);
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        write_reg(REG_GRAY_MODE, CFG_DATA_W'(gray));
        write_reg(REG_MASK_ENABLE, CFG_DATA_W'(mask_on));
    endtask

    // registers still at reset: zero size acts as 1x1, so every pixel closes a frame
    task automatic test_reset_defaults();
        idle_odds = 20;
        send_pixel(pix(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_pixel(pix(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
    endtask

    // colour luma without a mask, full-scale steps on each channel
    task automatic test_colour_unmasked();
        drain_results();
        set_frame(13'd3, 13'd2, 1'b0, 1'b0);
        send_pixel(pix(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_pixel(pix(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
        send_pixel(pix(8'hff, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_pixel(pix(8'h00, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00));
        send_pixel(pix(8'h00, 8'h00, 8'hff, 8'h00, 8'h00, 8'h00));
        send_pixel(pix(8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00));
    endtask

    // colour mask: any channel nonzero lets the pixel count
    task automatic test_colour_masked();
        drain_results();
        write_reg(REG_MASK_ENABLE, 13'd1);
        send_pixel(pix(8'h10, 8'h80, 8'hf0, 8'h00, 8'h00, 8'h00));
        send_pixel(pix(8'hc0, 8'h20, 8'h05, 8'h01, 8'h00, 8'h00));
        send_pixel(pix(8'h33, 8'h44, 8'h55, 8'h00, 8'h80, 8'h00));
        send_pixel(pix(8'hff, 8'h00, 8'hff, 8'h00, 8'h00, 8'hff));
        send_pixel(pix(8'h00, 8'hff, 8'h00, 8'hff, 8'hff, 8'hff));
        send_pixel(pix(8'h7f, 8'h7f, 8'h7f, 8'h00, 8'h00, 8'h00));
    endtask

    // grey mode: only red and mask_red matter, the other bytes carry junk
    task automatic test_grey_masked();
        drain_results();
        write_reg(REG_GRAY_MODE, 13'd1);
        send_pixel(pix(8'hc8, 8'hff, 8'hff, 8'h00, 8'hff, 8'hff));
        send_pixel(pix(8'h00, 8'h12, 8'h34, 8'h07, 8'h00, 8'h00));
        send_pixel(pix(8'hff, 8'h00, 8'h00, 8'hff, 8'h00, 8'h00));
        send_pixel(pix(8'h11, 8'haa, 8'h55, 8'h01, 8'h00, 8'h00));
        send_pixel(pix(8'hff, 8'h00, 8'hff, 8'h80, 8'h00, 8'h00));
        send_pixel(pix(8'h00, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00));
    endtask

    // width changed partway through a frame: the position is kept, the row end moves
    task automatic test_midframe_resize();
        drain_results();
        set_frame(13'd4, 13'd3, 1'b0, 1'b0);
        repeat (5) send_pixel(make_pixel(0));
        drain_results();
        // row 1 sits at column 1, which is now its last column
        write_reg(REG_FRAME_WIDTH, 13'd2);
        finish_frame(0);
        drain_results();
        write_reg(REG_FRAME_HEIGHT, 13'd2);
        repeat (3) send_pixel(make_pixel(2));
        drain_results();
        // widening reads line store entries left over from the earlier 4-wide frame
        write_reg(REG_FRAME_WIDTH, 13'd4);
        finish_frame(2);
    endtask

    // sizes past the store saturate: a stretch of an oversized row or column must not
    // close early; a smaller size written mid-frame then closes it
    task automatic test_size_saturation();
        drain_results();
        idle_odds = 5;
        set_frame(13'd8191, 13'd2, 1'b0, 1'b0);
        repeat (6) send_pixel(make_pixel(0));
        drain_results();
        // row 0 is open at column 6 and now ends at column 7
        write_reg(REG_FRAME_WIDTH, 13'd8);
        finish_frame(0);
        drain_results();
        // one column, rows past the maximum: no centre pixel, result is zero
        write_reg(REG_FRAME_WIDTH, 13'd0);
        write_reg(REG_FRAME_HEIGHT, 13'd8191);
        repeat (5) send_pixel(make_pixel(1));
        drain_results();
        write_reg(REG_FRAME_HEIGHT, 13'd7);
        finish_frame(1);
    endtask

    // whole frames with random size, mode and content; settings change between frames
    task automatic test_random_frames();
        int unsigned first_pixel;
        first_pixel = pixels_sent;
        while (pixels_sent - first_pixel < 1000) begin
            if ($urandom_range(0, 2) == 0) begin
                drain_results();
                set_frame(pick_size(40), pick_size(24), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
            end
            case ($urandom_range(0, 3))
                0:       idle_odds = 0;
                1:       idle_odds = 40;
                default: idle_odds = 12;
            endcase
            finish_frame($urandom_range(0, 2));
        end
    endtask

    // back-to-back frames with no idling on either side
    task automatic test_steady_tail();
        drain_results();
        idle_odds = 0;
        set_frame(13'd5, 13'd4, 1'b0, 1'b1);
        repeat (10) finish_frame($urandom_range(0, 2));
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_colour_unmasked();
        test_colour_masked();
        test_grey_masked();
        test_midframe_resize();
        test_size_saturation();
        test_random_frames();
        test_steady_tail();
        drain_results();
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------

    // ready drops in bursts while idling is on
    initial begin : result_backpressure
        int unsigned stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (idle_odds != 0 && $urandom_range(0, 99) < idle_odds / 2) begin
                stall_left = $urandom_range(0, 11);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // every accepted result against the oldest expected frame
    always @(posedge aclk) begin : result_check
        frame_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_contrast.size() == 0) begin
                report_mismatch($sformatf("unexpected result, tdata %h", m_tdata));
            end else begin
                want = pending_contrast.pop_front();
                if (m_tdata[16:0] !== want.mean)
                    report_mismatch($sformatf("contrast_mean %0d, expected %0d",
                                              m_tdata[16:0], want.mean));
                if (m_tdata[40:17] !== want.pixels)
                    report_mismatch($sformatf("counted_pixels %0d, expected %0d",
                                              m_tdata[40:17], want.pixels));
            end
        end
    end

    // hang guard
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout with %0d results outstanding", pending_contrast.size());
            $display("Verification failed");
            $finish;
        end
    end

endmodule
